### hw/rtl/sorted_top_k_insert_assert.svh
// Assertion macros shared by the sorted top-k insert RTL.
`ifndef SORTED_TOP_K_INSERT_ASSERT_SVH
`define SORTED_TOP_K_INSERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define STK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define STK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/stk_pkg.sv
// Types and constants of the sorted top-k insert block.
package stk_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TAG_W    = 16;
    localparam int SCORE_W  = 32;
    localparam int RIDX_W   = 4;

    // Input kind carried on tuser.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // One list slot.
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
    } t_slot;

    // Write request to the slot store.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_slot            data;
    } t_wr;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic signed [SCORE_W-1:0] read_score;
        logic [TAG_W-1:0]          read_tag;
        logic                      read_valid;
        logic [CNT_W-1:0]          entry_count;
        logic [CNT_W-1:0]          placed_at;
        logic                      accepted;
    } t_result;

endpackage

### hw/rtl/stk_store.sv
// Slot store: one write port and one registered read port.
module stk_store
    import stk_pkg::*;
(
    input  logic             i_clk,
    input  t_wr              i_wr,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_slot            o_rd_data
);

    t_slot r_mem [CAPACITY];
    t_slot r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/sorted_top_k_insert.sv
// Top level of the sorted top-k insert block: sequencer, comparator and result register.
//
//  channel | dir | handshake                  | contents
//  --------+-----+----------------------------+------------------------------------------
//  s       | in  | i_s_tvalid / o_s_tready    | tdata: tag, score, read index; tuser: action
//  m       | out | o_m_tvalid / i_m_tready    | tdata: accepted, placed, count, read fields
//
// A word is taken only in idle; the sequencer returns to idle as it offers the result word with the
// output free. A read passes the store read, read response and hand-off; a read past the entry
// count goes straight to the hand-off. An insert walks from the tail with one comparator, a store
// read and then a compare and move per slot moved; a read and compare stop the walk short of the
// head, then come the write and hand-off, and a walk that reaches the head goes straight to the
// write. A full list first tests the last slot; a rejected insert ends there. No new word is taken
// while an item is in work; a waiting result word holds until taken; reset empties the list at once.
module sorted_top_k_insert
    import stk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // [15:0] entry_tag, [47:16] entry_score, [51:48] read_index
    input  logic        i_s_tuser,  // [0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata   // [0] accepted, [5:1] placed_at, [10:6] entry_count,
                                    // [11] read_valid, [27:12] read_tag, [59:28] read_score
);

`include "sorted_top_k_insert_assert.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_PUT   = 3'd3;
    localparam logic [2:0] ST_RRESP = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);

    logic [2:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_filled, n_filled;
    logic              r_full_chk, n_full_chk;
    logic              r_is_read, n_is_read;
    t_slot             r_new, n_new;
    t_result           r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out, n_out;

    t_wr               wr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    t_slot             rd_data;

    logic              in_take;
    logic              score_ge;
    logic [RIDX_W-1:0] in_ridx;

    stk_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_take    = i_s_tvalid && o_s_tready;
    assign in_ridx    = i_s_tdata[51:48];

    // The one shared comparator: new score against the slot just read.
    assign score_ge = (r_new.score >= rd_data.score);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_j         = r_j;
        n_filled    = r_filled;
        n_full_chk  = r_full_chk;
        n_is_read   = r_is_read;
        n_new       = r_new;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        wr          = '0;
        rd_en       = 1'b0;
        rd_addr     = r_j;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_new.tag   = i_s_tdata[15:0];
                    n_new.score = i_s_tdata[47:16];
                    n_is_read   = (i_s_tuser == ACT_READ);
                    n_full_chk  = 1'b0;
                    n_res       = '0;
                    n_res.placed_at   = CAP_CNT;
                    n_res.entry_count = r_filled;
                    if (i_s_tuser == ACT_READ) begin
                        if (CNT_W'(in_ridx) < r_filled) begin
                            n_j     = IDX_W'(in_ridx);
                            n_state = ST_RD;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else if (r_filled == '0) begin
                        n_j     = '0;
                        n_state = ST_PUT;
                    end else if (r_filled < CAP_CNT) begin
                        n_j     = r_filled[IDX_W-1:0];
                        n_state = ST_RD;
                    end else begin
                        // Full list: first test against the last slot.
                        n_j        = LAST_IDX;
                        n_full_chk = 1'b1;
                        n_state    = ST_RD;
                    end
                end
            end
            ST_RD: begin
                rd_en   = 1'b1;
                rd_addr = (r_is_read || r_full_chk) ? r_j : r_j - 1'b1;
                n_state = r_is_read ? ST_RRESP : ST_CMP;
            end
            ST_CMP: begin
                if (r_full_chk) begin
                    // The last entry is dropped if the new one beats or ties it.
                    n_full_chk = 1'b0;
                    n_state    = score_ge ? ST_RD : ST_DONE;
                end else if (score_ge) begin
                    wr.en   = 1'b1;
                    wr.addr = r_j;
                    wr.data = rd_data;
                    n_j     = r_j - 1'b1;
                    n_state = (r_j == IDX_W'(1)) ? ST_PUT : ST_RD;
                end else begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                wr.en    = 1'b1;
                wr.addr  = r_j;
                wr.data  = r_new;
                if (r_filled < CAP_CNT) begin
                    n_filled = r_filled + 1'b1;
                end
                n_res.accepted    = 1'b1;
                n_res.placed_at   = CNT_W'(r_j);
                n_res.entry_count = n_filled;
                n_state           = ST_DONE;
            end
            ST_RRESP: begin
                n_res.read_valid = 1'b1;
                n_res.read_tag   = rd_data.tag;
                n_res.read_score = rd_data.score;
                n_state          = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_filled    <= '0;
            r_out_valid <= 1'b0;
            r_full_chk  <= 1'b0;
            r_is_read   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_filled    <= n_filled;
            r_out_valid <= n_out_valid;
            r_full_chk  <= n_full_chk;
            r_is_read   <= n_is_read;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_j   <= n_j;
        r_new <= n_new;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0, r_out};

    // Checks on the sequencer and the result word.
    `STK_ASSERT_NOW(a_fill_bound, 1'b1, r_filled <= CAP_CNT, "entry count above capacity")
    `STK_ASSERT_NEXT(a_fill_monotonic, 1'b1, r_filled >= $past(r_filled),
                     "entry count went down")
    `STK_ASSERT_NEXT(a_busy_after_take, in_take, r_state != ST_IDLE,
                     "sequencer idle right after taking a word")
    `STK_ASSERT_NOW(a_placed_in_list, r_out_valid && r_out.accepted,
                    r_out.placed_at < r_out.entry_count, "placed position outside the list")
    `STK_ASSERT_NOW(a_read_no_place, r_out_valid && r_out.read_valid,
                    !r_out.accepted && r_out.placed_at == CAP_CNT,
                    "read result carries an insert position")

endmodule
